// ===== hdl/cleb_pkg.sv =====
// ----------------------------------------------------------------------------
// cleb_pkg
// shared types, constants and index helpers for the console line edit buffer
// ----------------------------------------------------------------------------
`default_nettype none

package cleb_pkg;

   localparam int BUFFER_DEPTH = 128;
   localparam int IDX_MOD      = 2 * BUFFER_DEPTH;
   localparam int IDX_W        = $clog2(IDX_MOD);
   localparam int SLOT_W       = $clog2(BUFFER_DEPTH);

   localparam logic [7:0] KEY_CR   = 8'h0D;
   localparam logic [7:0] KEY_LF   = 8'h0A;
   localparam logic [7:0] KEY_DEL  = 8'h7F;
   localparam logic [7:0] KEY_KILL = 8'h15;
   localparam logic [7:0] KEY_BS   = 8'h08;
   localparam logic [7:0] KEY_EOF  = 8'h04;
   localparam logic [7:0] KEY_NUL  = 8'h00;
   localparam logic [7:0] COUNT_MAX = 8'hFF;

   localparam logic MODE_KEY  = 1'b0;
   localparam logic MODE_READ = 1'b1;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [IDX_W:0]    idx_wide_type;
   typedef logic [SLOT_W-1:0] slot_type;

   typedef enum logic [1:0] {
      ECHO_NONE  = 2'd0,
      ECHO_BYTE  = 2'd1,
      ECHO_ERASE = 2'd2
   } echo_kind_type;

   typedef enum logic [1:0] {
      RD_BYTE  = 2'd0,
      RD_EOF   = 2'd1,
      RD_EMPTY = 2'd2
   } read_status_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] key_code;
      logic       read_started;
   } req_type;

   typedef struct packed {
      echo_kind_type   echo_kind;
      logic [7:0]      echo_byte;
      logic [7:0]      erase_count;
      logic            line_ready;
      read_status_type read_status;
      logic [7:0]      read_byte;
      logic            read_line_end;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ_CHK,
      ST_KILL_CHK,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic read_empty;
      logic read_issue;
      logic read_finish;
      logic kill_issue;
      logic kill_step;
      logic key_exec;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic is_read;
      logic is_kill;
      logic read_empty;
      logic kill_empty;
      logic kill_more;
   } sts_type;

   function automatic idx_type idx_inc(input idx_type i);
      return (i == idx_type'(IDX_MOD - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic idx_type idx_dec(input idx_type i);
      return (i == '0) ? idx_type'(IDX_MOD - 1) : i - 1'b1;
   endfunction

   function automatic idx_type idx_dist(input idx_type hi, input idx_type lo);
      idx_wide_type t;
      if (hi >= lo) begin
         t = {1'b0, hi} - {1'b0, lo};
      end else begin
         t = {1'b0, hi} + idx_wide_type'(IDX_MOD) - {1'b0, lo};
      end
      return t[IDX_W-1:0];
   endfunction

   function automatic slot_type slot_of(input idx_type i);
      idx_type t;
      t = (i >= idx_type'(BUFFER_DEPTH)) ? i - idx_type'(BUFFER_DEPTH) : i;
      return t[SLOT_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== hdl/cleb_ram.sv =====
// ----------------------------------------------------------------------------
// cleb_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module cleb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/cleb_datapath.sv =====
// ----------------------------------------------------------------------------
// cleb_datapath
// line store, ring indices, result build-up and output register
// ----------------------------------------------------------------------------
`default_nettype none

module cleb_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cleb_pkg::req_type req_data,
   input  wire cleb_pkg::cmd_type cmd,
   output cleb_pkg::sts_type      sts,
   output cleb_pkg::rsp_type      rsp_data
);

   cleb_pkg::req_type  item_ff;
   cleb_pkg::rsp_type  res_ff, res_in;
   cleb_pkg::rsp_type  rsp_ff;
   cleb_pkg::idx_type  read_ff, read_in;
   cleb_pkg::idx_type  commit_ff, commit_in;
   cleb_pkg::idx_type  edit_ff, edit_in;
   cleb_pkg::idx_type  probe_ff, probe_in;

   logic                  wr_en;
   cleb_pkg::slot_type    wr_addr;
   logic [7:0]            wr_data;
   logic                  rd_en;
   cleb_pkg::slot_type    rd_addr;
   logic [7:0]            rd_data;

   logic [7:0]            key_byte;
   logic                  key_erase;
   logic                  key_full;
   cleb_pkg::idx_type     edit_next;
   logic                  kill_lf;

   cleb_ram #(
      .WIDTH(8),
      .DEPTH(cleb_pkg::BUFFER_DEPTH)
   ) u_line_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign key_byte  = (item_ff.key_code == cleb_pkg::KEY_CR) ? cleb_pkg::KEY_LF
                                                             : item_ff.key_code;
   assign key_erase = (item_ff.key_code == cleb_pkg::KEY_BS) ||
                      (item_ff.key_code == cleb_pkg::KEY_DEL);
   assign key_full  = cleb_pkg::idx_dist(edit_ff, read_ff) >=
                      cleb_pkg::idx_type'(cleb_pkg::BUFFER_DEPTH);
   assign edit_next = cleb_pkg::idx_inc(edit_ff);
   assign kill_lf   = (rd_data == cleb_pkg::KEY_LF);

   always_comb begin
      sts.is_read    = (item_ff.mode == cleb_pkg::MODE_READ);
      sts.is_kill    = (item_ff.mode == cleb_pkg::MODE_KEY) &&
                       (item_ff.key_code == cleb_pkg::KEY_KILL);
      sts.read_empty = (read_ff == commit_ff);
      sts.kill_empty = (edit_ff == commit_ff);
      sts.kill_more  = !kill_lf && (probe_ff != commit_ff);
   end

   // ram access
   always_comb begin
      wr_en   = cmd.key_exec && !key_erase && (item_ff.key_code != cleb_pkg::KEY_NUL) &&
                !key_full;
      wr_addr = cleb_pkg::slot_of(edit_ff);
      wr_data = key_byte;
      rd_en   = cmd.read_issue || cmd.kill_issue || (cmd.kill_step && sts.kill_more);
      if (cmd.read_issue) begin
         rd_addr = cleb_pkg::slot_of(read_ff);
      end else if (cmd.kill_issue) begin
         rd_addr = cleb_pkg::slot_of(cleb_pkg::idx_dec(edit_ff));
      end else begin
         rd_addr = cleb_pkg::slot_of(cleb_pkg::idx_dec(probe_ff));
      end
   end

   always_comb begin
      res_in    = res_ff;
      read_in   = read_ff;
      commit_in = commit_ff;
      edit_in   = edit_ff;
      probe_in  = probe_ff;
      if (cmd.capture) begin
         res_in = '0;
      end
      if (cmd.read_empty) begin
         res_in.read_status = cleb_pkg::RD_EMPTY;
      end
      if (cmd.read_finish) begin
         if (rd_data == cleb_pkg::KEY_EOF) begin
            if (!item_ff.read_started) begin
               read_in = cleb_pkg::idx_inc(read_ff);
            end
            res_in.read_status = cleb_pkg::RD_EOF;
         end else begin
            read_in               = cleb_pkg::idx_inc(read_ff);
            res_in.read_status    = cleb_pkg::RD_BYTE;
            res_in.read_byte      = rd_data;
            res_in.read_line_end  = kill_lf;
         end
      end
      if (cmd.kill_issue) begin
         probe_in = cleb_pkg::idx_dec(edit_ff);
      end
      if (cmd.kill_step && !kill_lf) begin
         edit_in          = probe_ff;
         res_in.echo_kind = cleb_pkg::ECHO_ERASE;
         if (res_ff.erase_count != cleb_pkg::COUNT_MAX) begin
            res_in.erase_count = res_ff.erase_count + 8'd1;
         end
         if (sts.kill_more) begin
            probe_in = cleb_pkg::idx_dec(probe_ff);
         end
      end
      if (cmd.key_exec) begin
         if (key_erase) begin
            if (edit_ff != commit_ff) begin
               edit_in            = cleb_pkg::idx_dec(edit_ff);
               res_in.echo_kind   = cleb_pkg::ECHO_ERASE;
               res_in.erase_count = 8'd1;
            end
         end else if (wr_en) begin
            edit_in          = edit_next;
            res_in.echo_kind = cleb_pkg::ECHO_BYTE;
            res_in.echo_byte = key_byte;
            if ((key_byte == cleb_pkg::KEY_LF) || (key_byte == cleb_pkg::KEY_EOF) ||
                (cleb_pkg::idx_dist(edit_next, read_ff) ==
                 cleb_pkg::idx_type'(cleb_pkg::BUFFER_DEPTH))) begin
               commit_in         = edit_next;
               res_in.line_ready = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_ff   <= '0;
         commit_ff <= '0;
         edit_ff   <= '0;
      end else begin
         read_ff   <= read_in;
         commit_ff <= commit_in;
         edit_ff   <= edit_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_ff <= probe_in;
      res_ff   <= res_in;
      if (cmd.capture) begin
         item_ff <= req_data;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_data = rsp_ff;

`ifndef SYNTHESIS
   a_ring_bound: assert property (@(posedge clock) disable iff (reset)
      cleb_pkg::idx_dist(edit_ff, read_ff) <= cleb_pkg::idx_type'(cleb_pkg::BUFFER_DEPTH))
      else $error("edit index ran past the ring size");

   a_commit_order: assert property (@(posedge clock) disable iff (reset)
      cleb_pkg::idx_dist(commit_ff, read_ff) <= cleb_pkg::idx_dist(edit_ff, read_ff))
      else $error("commit index ahead of edit index");

   a_erase_count: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load && (res_ff.echo_kind == cleb_pkg::ECHO_ERASE) |->
      res_ff.erase_count != 8'd0)
      else $error("erase result with zero count");
`endif

endmodule

`default_nettype wire

// ===== hdl/cleb_ctrl.sv =====
// ----------------------------------------------------------------------------
// cleb_ctrl
// item sequencer: decode, ram read wait, kill-line walk and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module cleb_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire cleb_pkg::sts_type sts,
   output cleb_pkg::cmd_type      cmd
);

   cleb_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cleb_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = cleb_pkg::ST_DECODE;
            end
         end
         cleb_pkg::ST_DECODE: begin
            if (sts.is_read) begin
               state_in = sts.read_empty ? cleb_pkg::ST_EMIT : cleb_pkg::ST_READ_CHK;
            end else if (sts.is_kill) begin
               state_in = sts.kill_empty ? cleb_pkg::ST_EMIT : cleb_pkg::ST_KILL_CHK;
            end else begin
               state_in = cleb_pkg::ST_EMIT;
            end
         end
         cleb_pkg::ST_READ_CHK: begin
            state_in = cleb_pkg::ST_EMIT;
         end
         cleb_pkg::ST_KILL_CHK: begin
            if (!sts.kill_more) begin
               state_in = cleb_pkg::ST_EMIT;
            end
         end
         cleb_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = cleb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cleb_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         cleb_pkg::ST_IDLE: begin
            req_ready   = !reset;
            cmd.capture = req_valid && !reset;
         end
         cleb_pkg::ST_DECODE: begin
            if (sts.is_read) begin
               cmd.read_empty = sts.read_empty;
               cmd.read_issue = !sts.read_empty;
            end else if (sts.is_kill) begin
               cmd.kill_issue = !sts.kill_empty;
            end else begin
               cmd.key_exec = 1'b1;
            end
         end
         cleb_pkg::ST_READ_CHK: begin
            cmd.read_finish = 1'b1;
         end
         cleb_pkg::ST_KILL_CHK: begin
            cmd.kill_step = 1'b1;
         end
         cleb_pkg::ST_EMIT: begin
            cmd.rsp_load = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cleb_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == cleb_pkg::ST_DECODE)
      else $error("accepted transfer not decoded");

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.read_empty, cmd.read_issue, cmd.read_finish,
                cmd.kill_issue, cmd.kill_step, cmd.key_exec, cmd.rsp_load}))
      else $error("more than one datapath command at once");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !cmd.rsp_load ##1 rsp_valid_ff)
      else $error("pending result overwritten or dropped");

   a_read_chk_entry: assert property (@(posedge clock) disable iff (reset)
      state_ff == cleb_pkg::ST_READ_CHK |-> $past(cmd.read_issue))
      else $error("read check without a ram read");
`endif

endmodule

`default_nettype wire

// ===== hdl/console_line_edit_buffer.sv =====
// ----------------------------------------------------------------------------
// console_line_edit_buffer
// cooked-mode keyboard line buffer: key store with echo, erase, kill-line
// and committed-byte reads over a ring of bytes
// ----------------------------------------------------------------------------
//  channel   ports                          payload
//  request   req_valid / req_ready          req_data  (cleb_pkg::req_type)
//  response  rsp_valid / rsp_ready          rsp_data  (cleb_pkg::rsp_type)
//
//  one item at a time, from accept to the load of the response register:
//  a key or backspace passes decode and emit, a read decode, the check of
//  its registered line store read and emit, a kill-line decode, a walk
//  step with one line store read per byte walked back, and emit
//  reset clears the three ring indices and holds the request side not ready;
//  the line store is not cleared
//  a stalled response holds the next result in the emit step, the request
//  side is ready again once the result moves into the response register
// ----------------------------------------------------------------------------
`default_nettype none

module console_line_edit_buffer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire cleb_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output cleb_pkg::rsp_type      rsp_data
);

   cleb_pkg::cmd_type cmd;
   cleb_pkg::sts_type sts;

   cleb_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   cleb_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .req_data(req_data),
      .cmd     (cmd),
      .sts     (sts),
      .rsp_data(rsp_data)
   );

endmodule

`default_nettype wire
